/* rtl/b64_pkg.sv */
// Shared types, constants and the character classifier for the base64 stream decoder.
package b64_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;
  localparam logic [1:0] SLOT_FOURTH = 2'd3;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAD,
    KIND_SPACE,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] sextet;
    logic       last;
  } item_t;

  function automatic item_t classify(input logic [7:0] c, input logic last);
    item_t r;
    r.kind   = KIND_BAD;
    r.sextet = 6'd0;
    r.last   = last;
    if (c inside {[8'h41:8'h5a]}) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7a]}) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'd62;
    end else if (c == 8'h2f) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'd63;
    end else if (c == 8'h3d) begin
      r.kind = KIND_PAD;
    end else if (c == 8'h20 || (c inside {[8'h09:8'h0d]})) begin
      r.kind = KIND_SPACE;
    end
    return r;
  endfunction

endpackage

/* rtl/b64_front.sv */
// Input stage: accept characters, classify them and drop interior whitespace.
module b64_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      char_code_i,
  input  logic            end_of_text_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output b64_pkg::item_t  push_item_o,
  output logic            push_valid_o,
  input  logic            push_ready_i
);

  b64_pkg::item_t item_d, item_q;
  logic           valid_d, valid_q;
  logic           in_acc;
  logic           keep;

  assign in_ready_o = !valid_q || push_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    item_d  = b64_pkg::classify(char_code_i, end_of_text_i);
    keep    = (item_d.kind != b64_pkg::KIND_SPACE) || end_of_text_i;
    valid_d = valid_q && !push_ready_i;
    if (in_acc) begin
      valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= item_d;
    end
  end

  assign push_item_o  = item_q;
  assign push_valid_o = valid_q;

endmodule

/* rtl/b64_queue.sv */
// Short queue of classified characters between the front and the decode stage.
module b64_queue #(
  parameter int unsigned Depth = b64_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b64_pkg::item_t  push_item_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output b64_pkg::item_t  pop_item_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] count_d, count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/b64_back.sv */
// Decode stage: group tracking, byte assembly, end-of-text verdict and output register.
module b64_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b64_pkg::item_t  pop_item_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  output logic [7:0]      data_byte_o,
  output logic            byte_valid_o,
  output logic            done_res_o,
  output logic            error_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);

  logic [1:0] slot_d, slot_q;
  logic [5:0] left_d, left_q;
  logic       pad_exp_d, pad_exp_q;
  logic       err_d, err_q;
  logic       any_d, any_q;

  logic       have_byte;
  logic [7:0] byte_val;
  logic       emit, pop, bad;

  logic       out_valid_d, out_valid_q;
  logic [7:0] data_q;
  logic       bv_q, done_q, err_out_q;

  always_comb begin
    slot_d    = slot_q;
    left_d    = left_q;
    pad_exp_d = pad_exp_q;
    err_d     = err_q;
    any_d     = any_q;
    have_byte = 1'b0;
    byte_val  = 8'd0;
    if (!err_q) begin
      case (pop_item_i.kind)
        b64_pkg::KIND_BAD: begin
          err_d = 1'b1;
        end
        b64_pkg::KIND_PAD: begin
          if (pad_exp_q) begin
            pad_exp_d = 1'b0;
            slot_d    = b64_pkg::SLOT_FIRST;
          end else if (slot_q == b64_pkg::SLOT_FIRST || slot_q == b64_pkg::SLOT_SECOND) begin
            err_d = 1'b1;
          end else if (slot_q == b64_pkg::SLOT_THIRD) begin
            pad_exp_d = 1'b1;
            slot_d    = b64_pkg::SLOT_FOURTH;
          end else begin
            slot_d = b64_pkg::SLOT_FIRST;
          end
        end
        b64_pkg::KIND_DATA: begin
          if (pad_exp_q) begin
            err_d = 1'b1;
          end else begin
            any_d = 1'b1;
            case (slot_q)
              b64_pkg::SLOT_FIRST: begin
                left_d = pop_item_i.sextet;
                slot_d = b64_pkg::SLOT_SECOND;
              end
              b64_pkg::SLOT_SECOND: begin
                byte_val  = {left_q, pop_item_i.sextet[5:4]};
                left_d    = {2'b00, pop_item_i.sextet[3:0]};
                slot_d    = b64_pkg::SLOT_THIRD;
                have_byte = 1'b1;
              end
              b64_pkg::SLOT_THIRD: begin
                byte_val  = {left_q[3:0], pop_item_i.sextet[5:2]};
                left_d    = {4'b0000, pop_item_i.sextet[1:0]};
                slot_d    = b64_pkg::SLOT_FOURTH;
                have_byte = 1'b1;
              end
              default: begin
                byte_val  = {left_q[1:0], pop_item_i.sextet};
                left_d    = 6'd0;
                slot_d    = b64_pkg::SLOT_FIRST;
                have_byte = 1'b1;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
    bad = err_d || !any_d || (slot_d == b64_pkg::SLOT_SECOND);
    if (pop_item_i.last) begin
      slot_d    = b64_pkg::SLOT_FIRST;
      left_d    = 6'd0;
      pad_exp_d = 1'b0;
      err_d     = 1'b0;
      any_d     = 1'b0;
    end
  end

  assign emit        = have_byte || pop_item_i.last;
  assign pop_ready_o = !emit || !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= b64_pkg::SLOT_FIRST;
      left_q      <= 6'd0;
      pad_exp_q   <= 1'b0;
      err_q       <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        slot_q    <= slot_d;
        left_q    <= left_d;
        pad_exp_q <= pad_exp_d;
        err_q     <= err_d;
        any_q     <= any_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      data_q    <= byte_val;
      bv_q      <= have_byte;
      done_q    <= pop_item_i.last;
      err_out_q <= pop_item_i.last && bad;
    end
  end

  assign data_byte_o  = data_q;
  assign byte_valid_o = bv_q;
  assign done_res_o   = done_q;
  assign error_o      = err_out_q;
  assign out_valid_o  = out_valid_q;

endmodule

/* rtl/base64_stream_decoder.sv */
// Top level of the base64 stream decoder: front stage, queue and decode stage.
//
// Decodes standard base64 text at one character per clock. Each transaction on
// the input carries one character; a transaction on the output is produced when
// a byte completes (second, third and fourth sextet of a group) or when the
// character flagged end_of_text arrives, which carries done_res and the error
// verdict. Whitespace not flagged end_of_text is skipped and yields no output.
// A character passes the registered classifier, a QueueDepth-entry queue and
// the decode stage with its output register. Throughput is one character per
// cycle while the output is taken, and the queue absorbs stalls so the input
// keeps accepting behind a held result until the queue and the front register
// are full.
module base64_stream_decoder #(
  parameter int unsigned QueueDepth = b64_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       done_res_o,
  output logic       error_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  b64_pkg::item_t push_item, pop_item;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  b64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_code_i  (char_code_i),
    .end_of_text_i(end_of_text_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  b64_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  b64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_item_i   (pop_item),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .data_byte_o  (data_byte_o),
    .byte_valid_o (byte_valid_o),
    .done_res_o   (done_res_o),
    .error_o      (error_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

/* tb/sv/base64_stream_decoder_tb.sv */
// Self-checking testbench for the base64 stream decoder: directed and random texts.
`timescale 1ns / 100ps

module base64_stream_decoder_tb;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_CHARS = 1100;
  localparam int unsigned STEADY_FROM  = 400;
  localparam int unsigned STEADY_TO    = 650;
  localparam logic [7:0]  CHAR_PAD     = 8'h3d;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;
  localparam logic [7:0]  CHAR_TAB     = 8'h09;

  typedef struct packed {
    logic [7:0] code;
    logic       eot;
  } char_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       done;
    logic       error;
  } decoded_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic [7:0] char_code     = 8'h00;
  logic       end_of_text   = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       done_res;
  logic       error;
  logic       out_valid;
  logic       out_ready     = 1'b0;

  char_item_t pending_chars[$];
  decoded_t   expected_results[$];

  logic [1:0] slot;
  logic [5:0] leftover;
  logic       pad_pending;
  logic       malformed;
  logic       saw_sextet;

  int unsigned cycles;
  int unsigned n_accepted;
  int unsigned n_mismatches;
  int unsigned n_texts;
  int unsigned n_bytes;
  int unsigned n_error_verdicts;

  base64_stream_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_code_i  (char_code),
    .end_of_text_i(end_of_text),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_o  (data_byte),
    .byte_valid_o (byte_valid),
    .done_res_o   (done_res),
    .error_o      (error),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready)
  );

  always #5 clk_i = ~clk_i;

  function automatic b64_pkg::kind_e char_kind(input logic [7:0] c, output logic [5:0] sx);
    sx = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      sx = 6'(c - 8'h41);
      return b64_pkg::KIND_DATA;
    end
    if (c >= 8'h61 && c <= 8'h7a) begin
      sx = 6'(c - 8'h61 + 8'd26);
      return b64_pkg::KIND_DATA;
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      sx = 6'(c - 8'h30 + 8'd52);
      return b64_pkg::KIND_DATA;
    end
    if (c == 8'h2b) begin
      sx = 6'd62;
      return b64_pkg::KIND_DATA;
    end
    if (c == 8'h2f) begin
      sx = 6'd63;
      return b64_pkg::KIND_DATA;
    end
    if (c == CHAR_PAD) return b64_pkg::KIND_PAD;
    if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= 8'h0d)) return b64_pkg::KIND_SPACE;
    return b64_pkg::KIND_BAD;
  endfunction

  function automatic void clear_decoder_state();
    slot        = b64_pkg::SLOT_FIRST;
    leftover    = 6'd0;
    pad_pending = 1'b0;
    malformed   = 1'b0;
    saw_sextet  = 1'b0;
  endfunction

  function automatic bit predict_decode(input logic [7:0] c, input logic eot,
                                        output decoded_t res);
    b64_pkg::kind_e kind;
    logic [5:0]     sx;
    bit             have_byte;
    kind      = char_kind(c, sx);
    have_byte = 1'b0;
    res       = '0;
    if (!malformed && kind != b64_pkg::KIND_SPACE) begin
      case (kind)
        b64_pkg::KIND_BAD: malformed = 1'b1;
        b64_pkg::KIND_PAD: begin
          if (pad_pending) begin
            pad_pending = 1'b0;
            slot        = b64_pkg::SLOT_FIRST;
          end else if (slot == b64_pkg::SLOT_FIRST || slot == b64_pkg::SLOT_SECOND) begin
            malformed = 1'b1;
          end else if (slot == b64_pkg::SLOT_THIRD) begin
            pad_pending = 1'b1;
            slot        = b64_pkg::SLOT_FOURTH;
          end else begin
            slot = b64_pkg::SLOT_FIRST;
          end
        end
        default: begin
          if (pad_pending) begin
            malformed = 1'b1;
          end else begin
            saw_sextet = 1'b1;
            case (slot)
              b64_pkg::SLOT_FIRST: begin
                leftover = sx;
                slot     = b64_pkg::SLOT_SECOND;
              end
              b64_pkg::SLOT_SECOND: begin
                res.data_byte = {leftover, sx[5:4]};
                leftover      = {2'b00, sx[3:0]};
                slot          = b64_pkg::SLOT_THIRD;
                have_byte     = 1'b1;
              end
              b64_pkg::SLOT_THIRD: begin
                res.data_byte = {leftover[3:0], sx[5:2]};
                leftover      = {4'b0000, sx[1:0]};
                slot          = b64_pkg::SLOT_FOURTH;
                have_byte     = 1'b1;
              end
              default: begin
                res.data_byte = {leftover[1:0], sx};
                leftover      = 6'd0;
                slot          = b64_pkg::SLOT_FIRST;
                have_byte     = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
    if (!have_byte && !eot) return 1'b0;
    res.byte_valid = have_byte;
    res.done       = eot;
    if (eot) begin
      res.error = malformed || !saw_sextet || slot == b64_pkg::SLOT_SECOND;
      clear_decoder_state();
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + 8'(s);
    if (s < 6'd52) return 8'h61 + 8'(s - 6'd26);
    if (s < 6'd62) return 8'h30 + 8'(s - 6'd52);
    if (s == 6'd62) return 8'h2b;
    return 8'h2f;
  endfunction

  function automatic logic [7:0] space_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
  endfunction

  task automatic queue_text(input logic [7:0] text[$]);
    char_item_t ci;
    for (int i = 0; i < text.size(); i++) begin
      ci.code       = text[i];
      ci.eot        = (i == text.size() - 1);
      pending_chars = {pending_chars, ci};
    end
  endtask

  task automatic queue_string(input string s);
    logic [7:0] text[$];
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch   = s[i];
      text = {text, ch};
    end
    queue_text(text);
  endtask

  task automatic queue_random_text();
    logic [7:0] raw[$];
    logic [7:0] text[$];
    logic [5:0] sextets[$];
    logic [7:0] b0, b1, b2, ch;
    logic [5:0] sx;
    int         n, rem, pads;
    n = 0;
    if ($urandom_range(0, 99) < 78) begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        ch  = 8'($urandom_range(0, 255));
        raw = {raw, ch};
      end
      pads = 0;
      for (int i = 0; i < n; i += 3) begin
        rem = n - i;
        b0  = raw[i];
        b1  = (rem > 1) ? raw[i+1] : 8'h00;
        b2  = (rem > 2) ? raw[i+2] : 8'h00;
        sx      = b0[7:2];
        sextets = {sextets, sx};
        sx      = {b0[1:0], b1[7:4]};
        sextets = {sextets, sx};
        if (rem > 1) begin
          sx      = {b1[3:0], b2[7:6]};
          sextets = {sextets, sx};
        end
        if (rem > 2) begin
          sx      = b2[5:0];
          sextets = {sextets, sx};
        end
        if (rem < 3) pads = $urandom_range(0, 3 - rem);
      end
      foreach (sextets[i]) begin
        if ($urandom_range(0, 9) == 0) begin
          ch   = space_char();
          text = {text, ch};
        end
        ch   = sextet_char(sextets[i]);
        text = {text, ch};
      end
      for (int i = 0; i < pads; i++) text = {text, CHAR_PAD};
      if ($urandom_range(0, 7) == 0) begin
        ch   = space_char();
        text = {text, ch};
      end
      if (text.size() > 0 && $urandom_range(0, 9) == 0) begin
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0:       ch = CHAR_PAD;
          1:       ch = sextet_char(6'($urandom_range(0, 63)));
          default: ch = 8'($urandom_range(0, 255));
        endcase
        text = {text, ch};
      end
    end
    if (text.size() == 0) begin
      ch   = space_char();
      text = {text, ch};
    end
    queue_text(text);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at cycle %0d on %s: expected 0x%0h, got 0x%0h",
             cycles, what, want, got);
    n_mismatches++;
  endtask

  // Driver: hold the payload until the transaction completes, then advance.
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t res;
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      char_code   <= 8'h00;
      end_of_text <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_accepted++;
        if (predict_decode(char_code, end_of_text, res)) begin
          expected_results = {expected_results, res};
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 &&
            ((n_accepted >= STEADY_FROM && n_accepted < STEADY_TO) ||
             $urandom_range(0, 99) >= 37)) begin
          char_item_t next_char;
          next_char = pending_chars.pop_front();
          char_code   <= next_char.code;
          end_of_text <= next_char.eot;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'd0,
                          32'({data_byte, byte_valid, done_res, error}));
        end else begin
          want = expected_results.pop_front();
          if (byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
          if (data_byte !== want.data_byte)
            report_mismatch("data_byte", 32'(want.data_byte), 32'(data_byte));
          if (done_res !== want.done)
            report_mismatch("done_res", 32'(want.done), 32'(done_res));
          if (error !== want.error)
            report_mismatch("error", 32'(want.error), 32'(error));
          if (want.byte_valid) n_bytes++;
          if (want.done) n_texts++;
          if (want.done && want.error) n_error_verdicts++;
        end
      end
      out_ready <= (n_accepted >= STEADY_FROM && n_accepted < STEADY_TO) ||
                   $urandom_range(0, 99) >= 37;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [7:0] odd_chars[$];
    clear_decoder_state();
    queue_string("TWFu");
    queue_string("TQ==");
    queue_string("+/9");
    queue_string("=");
    queue_string("T=");
    queue_string("TQ=A");
    queue_string("TQ=");
    odd_chars = '{CHAR_TAB};
    queue_text(odd_chars);
    queue_string("T");
    odd_chars = '{8'h00};
    queue_text(odd_chars);
    odd_chars = '{8'hff};
    queue_text(odd_chars);
    while (pending_chars.size() < RANDOM_CHARS) queue_random_text();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d characters decoded into %0d texts, %0d bytes checked",
             n_accepted, n_texts, n_bytes);
    $display("%0d texts reported malformed, %0d mismatches", n_error_verdicts, n_mismatches);
    if (n_mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* base64_stream_decoder.f */
rtl/b64_pkg.sv
rtl/b64_front.sv
rtl/b64_queue.sv
rtl/b64_back.sv
rtl/base64_stream_decoder.sv
tb/sv/base64_stream_decoder_tb.sv
